// File: hw/rtl/abpf_pkg.sv
// Shared types and constants of the box pair finder.
// Used by abpf_cell and the top level.
`default_nettype none
package abpf_pkg;
    localparam int SLOT_W = 6;
    localparam int BODY_W = 16;
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;
    localparam logic [SLOT_W-1:0] HIT_LIMIT   = 6'd63;

    typedef struct packed {
        logic wr;
        logic clr;
        logic start;
        logic adv;
        logic sweep;
        logic probe_en;
    } t_ctl;

    typedef struct packed {
        logic              valid;
        logic [BODY_W-1:0] body;
        logic              stat;
    } t_ent;
endpackage
`default_nettype wire

// File: hw/rtl/abpf_cell.sv
// One table slot: holds its box entry, passes the walk token on,
// and tests its entry against the broadcast probe. Depends on abpf_pkg.
`default_nettype none
module abpf_cell import abpf_pkg::*; #(
    parameter int CB  = 32,
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [BODY_W-1:0] i_body,
    input  wire logic              i_stat,
    input  wire logic [4*CB-1:0]   i_box,
    input  wire logic [4*CB-1:0]   i_probe_box,
    input  wire logic [BODY_W-1:0] i_probe_body,
    input  wire logic              i_probe_stat,
    input  wire logic              i_tok,
    output logic                   o_tok,
    output logic                   o_hit,
    output t_ent                   o_ent,
    output logic [4*CB-1:0]        o_box
);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic              r_valid;
    logic [BODY_W-1:0] r_body;
    logic              r_stat;
    logic [4*CB-1:0]   r_box;
    logic              r_tok;
    logic              sel;
    logic              meet;
    logic signed [CB-1:0] a_lx, a_ly, a_hx, a_hy, b_lx, b_ly, b_hx, b_hy;

    assign sel = (i_slot == MY_SLOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            if (i_ctl.wr && sel) begin
                r_valid <= 1'b1;
            end else if (i_ctl.clr && sel) begin
                r_valid <= 1'b0;
            end
            if (i_ctl.start) begin
                r_tok <= (IDX == 0);
            end else if (i_ctl.adv) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && sel) begin
            r_body <= i_body;
            r_stat <= i_stat;
            r_box  <= i_box;
        end
    end

    assign {a_hy, a_hx, a_ly, a_lx} = i_probe_box;
    assign {b_hy, b_hx, b_ly, b_lx} = r_box;

    always_comb begin
        meet = !(a_hx < b_lx) && !(b_hx < a_lx) && !(a_hy < b_ly) && !(b_hy < a_ly);
        o_hit = r_tok && r_valid && i_ctl.probe_en && meet;
        if (i_ctl.sweep && ((r_body == i_probe_body) || (r_stat && i_probe_stat))) begin
            o_hit = 1'b0;
        end
    end

    assign o_tok       = r_tok;
    assign o_ent.valid = r_tok & r_valid;
    assign o_ent.body  = r_tok ? r_body : '0;
    assign o_ent.stat  = r_tok & r_stat;
    assign o_box       = r_tok ? r_box : '0;
endmodule
`default_nettype wire

// File: hw/rtl/aabb_broad_phase_pair_finder_top.sv
// A sweep or query walks a token along TABLE_SLOTS cells, one cell
// per cycle while the output is not stalled, then gives the closing word.
// Insert and remove write their slot when taken and give no word. Output stalls hold the walk.
// No new word is taken until the running sweep or query has closed (o_stall).
// Reset (synchronous, active low) clears all valid bits and the walk at once.
`default_nettype none
module aabb_broad_phase_pair_finder_top import abpf_pkg::*; #(
    parameter int TABLE_SLOTS = 64,
    parameter int COORD_BITS  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic [5:0]        i_slot,
    input  wire logic [15:0]       i_body_id,
    input  wire logic              i_is_static,
    input  wire logic signed [31:0] i_min_x,
    input  wire logic signed [31:0] i_min_y,
    input  wire logic signed [31:0] i_max_x,
    input  wire logic signed [31:0] i_max_y,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_found,
    output logic [5:0]             o_first_slot,
    output logic [5:0]             o_second_slot,
    output logic                   o_last
);
    localparam int CB = COORD_BITS;

    logic              acc, adv, hit_any, emit_hit;
    t_ctl              ctl;
    logic [4*CB-1:0]   in_box, probe_box;
    logic [TABLE_SLOTS-1:0] tok, hit;
    t_ent              ents [TABLE_SLOTS];
    logic [4*CB-1:0]   boxes [TABLE_SLOTS];
    t_ent              bus_ent;
    logic [4*CB-1:0]   bus_box;

    logic              r_busy, r_sweep, r_tail, r_row_v, r_row_st;
    logic [BODY_W-1:0] r_row_body;
    logic [4*CB-1:0]   r_row_box, r_qbox;
    logic [SLOT_W-1:0] r_slot, r_pos, r_cnt;
    logic              r_ov, r_found, r_last;
    logic [SLOT_W-1:0] r_first, r_second;

    assign in_box  = {i_max_y[CB-1:0], i_max_x[CB-1:0], i_min_y[CB-1:0], i_min_x[CB-1:0]};
    assign o_stall = r_busy;
    assign acc     = i_valid && !r_busy;
    assign adv     = r_busy && (!r_ov || !i_stall);

    assign ctl.wr       = acc && (i_mode == MODE_INSERT);
    assign ctl.clr      = acc && (i_mode == MODE_REMOVE);
    assign ctl.start    = acc && ((i_mode == MODE_SWEEP) || (i_mode == MODE_QUERY));
    assign ctl.adv      = adv;
    assign ctl.sweep    = r_sweep;
    assign ctl.probe_en = r_sweep ? r_row_v : 1'b1;
    assign probe_box    = r_sweep ? r_row_box : r_qbox;

    for (genvar j = 0; j < TABLE_SLOTS; j++) begin : g_cell
        logic tin;
        if (j == 0) begin : g_head
            assign tin = 1'b0;
        end else begin : g_link
            assign tin = tok[j-1];
        end
        abpf_cell #(.CB(CB), .IDX(j)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_slot(i_slot),
            .i_body(i_body_id), .i_stat(i_is_static), .i_box(in_box),
            .i_probe_box(probe_box), .i_probe_body(r_row_body),
            .i_probe_stat(r_row_st), .i_tok(tin), .o_tok(tok[j]),
            .o_hit(hit[j]), .o_ent(ents[j]), .o_box(boxes[j])
        );
    end

    always_comb begin
        bus_ent = '0;
        bus_box = '0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            bus_ent = bus_ent | ents[k];
            bus_box = bus_box | boxes[k];
        end
    end

    assign hit_any  = |hit;
    assign emit_hit = hit_any && (r_cnt != HIT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_tail  <= 1'b0;
            r_row_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (ctl.start) begin
                r_busy  <= 1'b1;
                r_tail  <= 1'b0;
                r_row_v <= 1'b0;
            end else if (adv) begin
                r_tail <= tok[TABLE_SLOTS-1];
                if (r_sweep && (r_pos == r_slot)) begin
                    r_row_v <= bus_ent.valid;
                end
                if (r_tail) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv && (r_tail || emit_hit)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_sweep <= (i_mode == MODE_SWEEP);
            r_slot  <= i_slot;
            r_qbox  <= in_box;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else if (adv) begin
            r_pos <= r_pos + 1'b1;
            if (r_sweep && (r_pos == r_slot)) begin
                r_row_body <= bus_ent.body;
                r_row_st   <= bus_ent.stat;
                r_row_box  <= bus_box;
            end
            if (r_tail) begin
                r_found  <= 1'b0;
                r_first  <= '0;
                r_second <= '0;
                r_last   <= 1'b1;
            end else if (emit_hit) begin
                r_cnt    <= r_cnt + 1'b1;
                r_found  <= 1'b1;
                r_first  <= r_sweep ? r_slot : r_pos;
                r_second <= r_sweep ? r_pos : '0;
                r_last   <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_found       = r_found;
    assign o_first_slot  = r_first;
    assign o_second_slot = r_second;
    assign o_last        = r_last;

    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok)) else $error("walk token not one-hot");
    a_tail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail |-> (tok == '0)) else $error("token left while closing");
    a_idle_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (tok == '0)) else $error("token live while idle");
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_found) else $error("closing word marked found");
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench of the box pair finder: directed and random insert, remove, sweep, query words.
// Expected results come from a predictor in this file; depends on abpf_pkg and the top level.
`timescale 1ns / 100ps
`default_nettype none
module tb import abpf_pkg::*;;

    localparam int SLOTS = 64;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic       found;
        logic [5:0] first;
        logic [5:0] second;
        logic       last;
    } t_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = MODE_INSERT;
    logic [5:0]  i_slot = '0;
    logic [15:0] i_body_id = '0;
    logic        i_is_static = 1'b0;
    logic signed [31:0] i_min_x = '0, i_min_y = '0, i_max_x = '0, i_max_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_found;
    logic [5:0]  o_first_slot, o_second_slot;
    logic        o_last;

    aabb_broad_phase_pair_finder_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_slot(i_slot), .i_body_id(i_body_id),
        .i_is_static(i_is_static), .i_min_x(i_min_x), .i_min_y(i_min_y),
        .i_max_x(i_max_x), .i_max_y(i_max_y), .o_valid(o_valid), .i_stall(i_stall),
        .o_found(o_found), .o_first_slot(o_first_slot),
        .o_second_slot(o_second_slot), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic              tbl_valid [SLOTS];
    logic [15:0]       tbl_body  [SLOTS];
    logic              tbl_static[SLOTS];
    logic signed [31:0] tbl_lx[SLOTS], tbl_ly[SLOTS], tbl_hx[SLOTS], tbl_hy[SLOTS];

    t_pair pending_pairs[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_recv = 1'b0;

    function automatic bit boxes_touch(input logic signed [31:0] alx, aly, ahx, ahy,
                                       input logic signed [31:0] blx, bly, bhx, bhy);
        if (ahx < blx || bhx < alx) return 1'b0;
        if (ahy < bly || bhy < aly) return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_word(input logic [1:0] mode, input logic [5:0] slot,
                                input logic [15:0] body, input logic stat,
                                input logic signed [31:0] lx, ly, hx, hy);
        int n;
        t_pair r;
        n = 0;
        case (mode)
            MODE_INSERT: begin
                tbl_valid[slot] = 1'b1;
                tbl_body[slot] = body;
                tbl_static[slot] = stat;
                tbl_lx[slot] = lx; tbl_ly[slot] = ly; tbl_hx[slot] = hx; tbl_hy[slot] = hy;
            end
            MODE_REMOVE: tbl_valid[slot] = 1'b0;
            MODE_SWEEP: begin
                if (tbl_valid[slot]) begin
                    for (int j = slot; j < SLOTS; j++) begin
                        if (!tbl_valid[j]) continue;
                        if (tbl_body[j] == tbl_body[slot]) continue;
                        if (tbl_static[j] && tbl_static[slot]) continue;
                        if (n >= 63) break;
                        if (boxes_touch(tbl_lx[slot], tbl_ly[slot], tbl_hx[slot], tbl_hy[slot],
                                        tbl_lx[j], tbl_ly[j], tbl_hx[j], tbl_hy[j])) begin
                            r = '{1'b1, slot, 6'(j), 1'b0};
                            pending_pairs.push_back(r);
                            n++;
                        end
                    end
                end
                pending_pairs.push_back(t_pair'{1'b0, 6'd0, 6'd0, 1'b1});
            end
            default: begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (n >= 63) break;
                    if (tbl_valid[j] && boxes_touch(lx, ly, hx, hy,
                                       tbl_lx[j], tbl_ly[j], tbl_hx[j], tbl_hy[j])) begin
                        pending_pairs.push_back(t_pair'{1'b1, 6'(j), 6'd0, 1'b0});
                        n++;
                    end
                end
                pending_pairs.push_back(t_pair'{1'b0, 6'd0, 6'd0, 1'b1});
            end
        endcase
    endtask

    // Receiver stall and result check.
    always @(posedge i_clk) begin
        t_pair got, want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_found, o_first_slot, o_second_slot, o_last};
                if (pending_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: got %b/%0d/%0d/%b",
                                 got.found, got.first, got.second, got.last);
                end else begin
                    want = pending_pairs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: want %b/%0d/%0d/%b got %b/%0d/%0d/%b",
                                     want.found, want.first, want.second, want.last,
                                     got.found, got.first, got.second, got.last);
                    end
                end
            end
        end
        i_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("aabb_broad_phase_pair_finder_top: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [5:0] slot,
                             input logic [15:0] body, input logic stat,
                             input logic signed [31:0] lx, ly, hx, hy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode; i_slot <= slot; i_body_id <= body; i_is_static <= stat;
        i_min_x <= lx; i_min_y <= ly; i_max_x <= hx; i_max_y <= hy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(mode, slot, body, stat, lx, ly, hx, hy);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int span);
        return $signed(32'($urandom_range(2 * span))) - span;
    endfunction

    task automatic send_insert_rand(input int slot_lim, input int body_lim);
        logic signed [31:0] ax, ay, bx, by;
        ax = rand_coord(1000); ay = rand_coord(1000);
        bx = ax + $urandom_range(400); by = ay + $urandom_range(400);
        if ($urandom_range(19) == 0) bx = ax - 1;
        send_word(MODE_INSERT, 6'($urandom_range(slot_lim)), 16'($urandom_range(body_lim)),
                  1'($urandom), ax, ay, bx, by);
    endtask

    task automatic test_directed;
        logic signed [31:0] mn, mx;
        mn = 32'sh8000_0000; mx = 32'sh7fff_ffff;
        send_word(MODE_SWEEP, 6'd0, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_QUERY, 6'd63, '0, 1'b0, mn, mn, mx, mx);
        send_word(MODE_REMOVE, 6'd5, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_INSERT, 6'd0, 16'h0000, 1'b0, mn, mn, 32'sd0, 32'sd0);
        send_word(MODE_INSERT, 6'd1, 16'hffff, 1'b1, 32'sd0, 32'sd0, mx, mx);
        send_word(MODE_INSERT, 6'd2, 16'h0000, 1'b0, mn, mn, mx, mx);
        send_word(MODE_INSERT, 6'd3, 16'h1234, 1'b1, 32'sd10, 32'sd10, 32'sd20, 32'sd20);
        send_word(MODE_INSERT, 6'd63, 16'hffff, 1'b1, mn, mn, mx, mx);
        send_word(MODE_INSERT, 6'd4, 16'h5555, 1'b0, 32'sd20, 32'sd20, 32'sd5, 32'sd5);
        send_word(MODE_SWEEP, 6'd0, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd1, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd3, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd4, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd63, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_INSERT, 6'd1, 16'haaaa, 1'b0, 32'sd21, 32'sd21, 32'sd30, 32'sd30);
        send_word(MODE_QUERY, 6'd0, '0, 1'b0, 32'sd20, 32'sd20, 32'sd20, 32'sd20);
        send_word(MODE_REMOVE, 6'd2, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_REMOVE, 6'd2, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd2, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_QUERY, 6'd7, '0, 1'b0, mx, mx, mn, mn);
        drain();
    endtask

    // Fill every slot with one huge box so a query overflows its hit limit.
    task automatic test_overflow;
        for (int s = 0; s < SLOTS; s++)
            send_word(MODE_INSERT, 6'(s), 16'(s), 1'(s & 1),
                      32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_word(MODE_QUERY, 6'd0, '0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_word(MODE_SWEEP, 6'd0, '0, 1'b0, '0, '0, '0, '0);
        send_word(MODE_SWEEP, 6'd1, '0, 1'b0, '0, '0, '0, '0);
        drain();
    endtask

    task automatic test_random(input int count, input int sidle, input int rstall);
        send_idle_pct = sidle; recv_stall_pct = rstall;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_insert_rand(63, 7);
                4:          send_word(MODE_REMOVE, 6'($urandom), '0, 1'b0, '0, '0, '0, '0);
                5, 6:       send_word(MODE_SWEEP, 6'($urandom), 16'($urandom), 1'($urandom),
                                      $signed($urandom), $signed($urandom),
                                      $signed($urandom), $signed($urandom));
                7:          send_word(MODE_QUERY, 6'($urandom), 16'($urandom), 1'($urandom),
                                      $signed($urandom), $signed($urandom),
                                      $signed($urandom), $signed($urandom));
                default:    send_word(MODE_QUERY, 6'($urandom), 16'($urandom), 1'($urandom),
                                      rand_coord(1200), rand_coord(1200),
                                      rand_coord(1200) + 600, rand_coord(1200) + 600);
            endcase
        end
        drain();
        send_idle_pct = 0; recv_stall_pct = 0;
    endtask

    // Hold the receiver off while sweeps keep coming, then let it drain.
    task automatic test_backpressure;
        hold_recv = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            begin
                for (int k = 0; k < 6; k++)
                    send_word(MODE_SWEEP, 6'(k), '0, 1'b0, '0, '0, '0, '0);
            end
        join
        drain();
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random(80, 0, 0);
        test_random(80, 74, 0);
        test_random(80, 0, 74);
        test_random(80, 11, 11);
        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("aabb_broad_phase_pair_finder_top: match");
        end else begin
            $display("aabb_broad_phase_pair_finder_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/abpf_pkg.sv
hw/rtl/abpf_cell.sv
hw/rtl/aabb_broad_phase_pair_finder_top.sv
tb/tb.sv
